// ===== sv/hashed_lru_block_buffer_cache_macros.svh =====
// Assertion macros shared by the buffer cache RTL.
// Included by the top level; depends on nothing.
`ifndef HASHED_LRU_BLOCK_BUFFER_CACHE_MACROS_SVH
`define HASHED_LRU_BLOCK_BUFFER_CACHE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define HLBC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define HLBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/hlbc_pkg.sv =====
// Shared types and constants for the hashed LRU block buffer cache.
// No dependencies.
package hlbc_pkg;

   localparam int DefNumBufs    = 32;
   localparam int DefNumBuckets = 13;

   localparam logic [1:0] CMD_GET     = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_PIN     = 2'd2;
   localparam logic [1:0] CMD_UNPIN   = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FREE   = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [1:0] ST_OVERFLOW  = 2'd3;

   localparam logic [31:0] STAMP_NONE = 32'hFFFF_FFFF;
   localparam logic [15:0] REFS_MAX   = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] device_id;
      logic [31:0] block_number;
      logic [4:0]  buffer_slot;
      logic [31:0] now_ticks;
   } req_type;

   typedef struct packed {
      logic [4:0]  slot_out;
      logic        was_hit;
      logic        need_read;
      logic [15:0] ref_count;
      logic [1:0]  status;
   } rsp_type;

   // One table entry as stored in memory.
   typedef struct packed {
      logic [15:0] device;
      logic [31:0] blk;
      logic [15:0] refs;
      logic [31:0] stamp;
      logic        valid;
      logic [5:0]  bucket;
      logic [15:0] order;
   } entry_type;

endpackage

// ===== sv/hlbc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module hlbc_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== sv/hashed_lru_block_buffer_cache.sv =====
// Hashed LRU buffer cache tag table: one request in, one response out per transfer.
// After reset a clearing pass writes every entry before requests are taken. A get
// first reduces the block number to its bucket (a reciprocal multiply at acceptance,
// a subtraction in the hash state), then scans the whole table from the entry memory,
// one entry per cycle, keeping a running hit and the oldest free entry of each
// bucket, then picks the victim and writes back the chosen entry. Its response is
// presented from the response state; the next request is taken only back in idle,
// so requests never overlap. The single read port of the entry memory makes the scan
// serial. Release, pin and unpin read, modify and write one entry in the slot read
// and slot write states. A stall holds the block in its response state only while
// an earlier response still waits in the output register.
// Depends on hlbc_pkg and the macros.
`include "hashed_lru_block_buffer_cache_macros.svh"

module hashed_lru_block_buffer_cache
   import hlbc_pkg::*;
#(
   parameter int NumBufs    = DefNumBufs,
   parameter int NumBuckets = DefNumBuckets
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int AW = (NumBufs > 1) ? $clog2(NumBufs) : 1;
   localparam int BW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
   localparam int CW = $clog2(NumBufs + 1);
   localparam int EW = $bits(entry_type);
   // Reciprocal of the bucket count, exact for every 32-bit block number.
   localparam int HS = $clog2(NumBuckets);
   localparam logic [32:0] HMUL = 33'((65'd1 << (32 + HS)) / 65'(NumBuckets) + 65'd1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_SCAN, S_PICK, S_WRITE, S_SLOT_RD, S_SLOT_WR, S_RESP
   } state_type;

   state_type        state_ff;
   req_type          req_ff;
   rsp_type          rsp_ff;
   rsp_type          res_ff;
   rsp_type          res_in;
   logic             rsp_valid_ff;
   logic [CW-1:0]    cnt_ff;       // address issued
   logic [CW-1:0]    rcnt_ff;      // address of data arriving
   logic             rd_pend_ff;
   logic [15:0]      icnt_ff;
   logic [BW-1:0]    tgt_ff;
   logic [31:0]      q_ff;
   // hit tracking
   logic             hit_ff;
   logic [AW-1:0]    hit_idx_ff;
   entry_type        hit_ent_ff;
   // oldest free entry of each bucket
   logic             bf_ok_ff   [NumBuckets];
   logic [AW-1:0]    bf_idx_ff  [NumBuckets];
   logic [31:0]      bf_stamp_ff[NumBuckets];
   logic [15:0]      bf_order_ff[NumBuckets];
   entry_type        bf_ent_ff  [NumBuckets];
   // victim selection over buckets
   logic             vic_ok_ff;
   logic [AW-1:0]    vic_idx_ff;
   entry_type        vic_ent_ff;
   logic             vic_move_ff;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   entry_type        wr_ent, rd_ent;
   logic [EW-1:0]    rd_raw;

   hlbc_ram #(.Width(EW), .Depth(NumBufs)) u_entries (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_ent),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );
   assign rd_ent = entry_type'(rd_raw);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Quotient of block number by bucket count, taken at acceptance.
   logic [64:0] hprod;
   assign hprod = {33'd0, req_data.block_number} * {32'd0, HMUL};

   logic [CW-1:0] clr_mod;
   // Reset bucket of entry cnt: counter wraps alongside via separate register.
   logic [BW-1:0] clr_bk_ff;

   logic slot_in_range;
   assign slot_in_range = ({{(32-5){1'b0}}, req_ff.buffer_slot} < 32'(NumBufs));
   assign clr_mod = cnt_ff;

   // Memory port drive.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_mod[AW-1:0];
      wr_ent  = '0;
      rd_addr = cnt_ff[AW-1:0];
      case (state_ff)
         S_CLEAR: begin
            wr_en         = 1'b1;
            wr_ent.bucket = 6'(clr_bk_ff);
            wr_ent.order  = 16'(cnt_ff);
         end
         S_SLOT_RD, S_IDLE: begin
            rd_addr = (state_ff == S_IDLE) ? AW'(req_data.buffer_slot)
                                           : AW'(req_ff.buffer_slot);
         end
         default: ;
      endcase
      if (state_ff == S_WRITE) begin
         if (hit_ff) begin
            wr_en   = (hit_ent_ff.refs != REFS_MAX);
            wr_addr = hit_idx_ff;
            wr_ent  = hit_ent_ff;
            wr_ent.refs  = hit_ent_ff.refs + 16'd1;
            wr_ent.valid = 1'b1;
         end else begin
            wr_en   = vic_ok_ff;
            wr_addr = vic_idx_ff;
            wr_ent  = vic_ent_ff;
            wr_ent.device = req_ff.device_id;
            wr_ent.blk    = req_ff.block_number;
            wr_ent.refs   = 16'd1;
            wr_ent.stamp  = req_ff.now_ticks;
            wr_ent.valid  = 1'b1;
            if (vic_move_ff) begin
               wr_ent.bucket = 6'(tgt_ff);
               wr_ent.order  = icnt_ff;
            end
         end
      end else if (state_ff == S_SLOT_WR) begin
         wr_addr = AW'(req_ff.buffer_slot);
         wr_ent  = rd_ent;
         if (req_ff.cmd == CMD_PIN) begin
            wr_en       = slot_in_range && (rd_ent.refs != REFS_MAX);
            wr_ent.refs = rd_ent.refs + 16'd1;
         end else begin
            wr_en       = slot_in_range && (rd_ent.refs != 16'd0);
            wr_ent.refs = rd_ent.refs - 16'd1;
            if (rd_ent.refs == 16'd1) begin
               wr_ent.stamp = req_ff.now_ticks;
            end
         end
      end
   end

   // Candidate checks for the scanned entry.
   logic          sc_match;
   logic [BW-1:0] sc_bk;
   logic          sc_free_better;
   assign sc_bk    = rd_ent.bucket[BW-1:0];
   assign sc_match = (rd_ent.bucket == 6'(tgt_ff)) && (rd_ent.device == req_ff.device_id)
                     && (rd_ent.blk == req_ff.block_number)
                     && (!hit_ff || rd_ent.order > hit_ent_ff.order);
   assign sc_free_better = (rd_ent.refs == 16'd0) &&
                     ((rd_ent.stamp < (bf_ok_ff[sc_bk] ? bf_stamp_ff[sc_bk] : STAMP_NONE))
                     || (bf_ok_ff[sc_bk] && rd_ent.stamp == bf_stamp_ff[sc_bk]
                         && rd_ent.order > bf_order_ff[sc_bk]));

   // Victim choice: target bucket first, else lowest other bucket.
   logic          pk_ok;
   logic [BW-1:0] pk_bk;
   always_comb begin
      pk_ok = bf_ok_ff[tgt_ff];
      pk_bk = tgt_ff;
      if (!pk_ok) begin
         for (int b = NumBuckets - 1; b >= 0; b--) begin
            if (bf_ok_ff[b] && BW'(b) != tgt_ff) begin
               pk_ok = 1'b1;
               pk_bk = BW'(b);
            end
         end
      end
   end

   // Build the response of a get or of a slot command.
   always_comb begin
      res_in = '0;
      if (state_ff == S_SLOT_WR) begin
         res_in.slot_out = req_ff.buffer_slot;
         if (slot_in_range) begin
            if (req_ff.cmd == CMD_PIN) begin
               if (rd_ent.refs == REFS_MAX) begin
                  res_in.status    = ST_OVERFLOW;
                  res_in.ref_count = REFS_MAX;
               end else begin
                  res_in.ref_count = rd_ent.refs + 16'd1;
               end
            end else if (rd_ent.refs == 16'd0) begin
               res_in.status = ST_UNDERFLOW;
            end else begin
               res_in.ref_count = rd_ent.refs - 16'd1;
            end
         end
      end else if (hit_ff) begin
         res_in.slot_out = 5'(hit_idx_ff);
         res_in.was_hit  = 1'b1;
         if (hit_ent_ff.refs == REFS_MAX) begin
            res_in.status    = ST_OVERFLOW;
            res_in.ref_count = REFS_MAX;
         end else begin
            res_in.ref_count = hit_ent_ff.refs + 16'd1;
            res_in.need_read = !hit_ent_ff.valid;
         end
      end else if (vic_ok_ff) begin
         res_in.slot_out  = 5'(vic_idx_ff);
         res_in.need_read = 1'b1;
         res_in.ref_count = 16'd1;
      end else begin
         res_in.status = ST_NO_FREE;
      end
   end

   // Sequencer, registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
         cnt_ff       <= '0;
         clr_bk_ff    <= '0;
         icnt_ff      <= 16'(NumBufs);
         rd_pend_ff   <= 1'b0;
      end else begin
         // Present a finished response once the output register is free.
         if (state_ff == S_RESP && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= res_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               cnt_ff    <= cnt_ff + CW'(1);
               clr_bk_ff <= (clr_bk_ff == BW'(NumBuckets - 1)) ? '0 : clr_bk_ff + BW'(1);
               if (cnt_ff == CW'(NumBufs - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  q_ff   <= 32'(hprod >> (32 + HS));
                  hit_ff <= 1'b0;
                  for (int b = 0; b < NumBuckets; b++) bf_ok_ff[b] <= 1'b0;
                  if (req_data.cmd == CMD_GET) begin
                     cnt_ff     <= '0;
                     rd_pend_ff <= 1'b1;
                     state_ff   <= S_HASH;
                  end else begin
                     state_ff <= S_SLOT_RD;
                  end
               end
            end
            S_HASH: begin
               // Finish the bucket index while entry 0 is read.
               tgt_ff   <= BW'(req_ff.block_number - 32'(q_ff * 32'(NumBuckets)));
               cnt_ff   <= CW'(1);
               rcnt_ff  <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               // Fold in the entry read last cycle, issue the next read.
               if (sc_match) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= rcnt_ff[AW-1:0];
                  hit_ent_ff <= rd_ent;
               end
               if (sc_free_better) begin
                  bf_ok_ff[sc_bk]    <= 1'b1;
                  bf_idx_ff[sc_bk]   <= rcnt_ff[AW-1:0];
                  bf_stamp_ff[sc_bk] <= rd_ent.stamp;
                  bf_order_ff[sc_bk] <= rd_ent.order;
                  bf_ent_ff[sc_bk]   <= rd_ent;
               end
               rcnt_ff <= rcnt_ff + CW'(1);
               cnt_ff  <= cnt_ff + CW'(1);
               if (rcnt_ff == CW'(NumBufs - 1)) begin
                  rd_pend_ff <= 1'b0;
                  state_ff   <= S_PICK;
               end
            end
            S_PICK: begin
               vic_ok_ff   <= pk_ok;
               vic_idx_ff  <= bf_idx_ff[pk_bk];
               vic_ent_ff  <= bf_ent_ff[pk_bk];
               vic_move_ff <= (pk_bk != tgt_ff);
               state_ff    <= S_WRITE;
            end
            S_WRITE: begin
               res_ff <= res_in;
               if (!hit_ff && vic_ok_ff && vic_move_ff) icnt_ff <= icnt_ff + 16'd1;
               state_ff <= S_RESP;
            end
            S_SLOT_RD: begin
               state_ff <= S_SLOT_WR;
            end
            S_SLOT_WR: begin
               res_ff   <= res_in;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               // Wait for the previous response to drain, then present.
               if (!rsp_valid_ff || !rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `HLBC_ASSERT_IMPL(a_scan_no_req, clock, reset, state_ff == S_SCAN, req_stall,
      "request accepted during scan")
   `HLBC_ASSERT_NEXT(a_resp_follows, clock, reset, state_ff == S_RESP && !rsp_stall,
      rsp_valid, "response not presented")
   `HLBC_ASSERT_IMPL(a_scan_reading, clock, reset, state_ff == S_SCAN, rd_pend_ff,
      "scan without pending read")
endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for the hashed LRU buffer cache tag table.
// Predicts each response from its own copy of the table; depends on hlbc_pkg and the RTL.
module tb_top
   import hlbc_pkg::*;
();

   localparam int NBUF = DefNumBufs;
   localparam int NBKT = DefNumBuckets;
   localparam longint CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   hashed_lru_block_buffer_cache DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // shadow table
   logic [15:0] tbl_dev [NBUF];
   logic [31:0] tbl_blk [NBUF];
   logic [15:0] tbl_refs [NBUF];
   logic [31:0] tbl_stamp [NBUF];
   logic        tbl_valid [NBUF];
   logic [5:0]  tbl_bkt [NBUF];
   logic [15:0] tbl_order [NBUF];
   logic [15:0] next_order;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      errors = 0;
   int      n_hits = 0, n_nofree = 0, n_under = 0, n_over = 0, n_rsp = 0;
   int      send_idle_pct = 23, recv_idle_pct = 46;
   bit      hold_off = 1'b0;
   longint  cycles = 0;

   // Mirrors: drawn block numbers so gets hit
   logic [15:0] seen_dev [$];
   logic [31:0] seen_blk [$];

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch on %s: got %0d expected %0d", what, got, want);
   endtask

   function automatic int oldest_free_in(input int bk);
      int best;
      logic [31:0] best_stamp;
      best = -1;
      best_stamp = STAMP_NONE;
      for (int i = 0; i < NBUF; i++) begin
         if (tbl_bkt[i] != bk || tbl_refs[i] != 0) continue;
         if (tbl_stamp[i] < best_stamp ||
             (best >= 0 && tbl_stamp[i] == best_stamp && tbl_order[i] > tbl_order[best])) begin
            best = i;
            best_stamp = tbl_stamp[i];
         end
      end
      return best;
   endfunction

   // Apply one request to the shadow table and return the response it gives.
   function automatic rsp_type cache_access(input req_type rq);
      rsp_type r;
      int bk, hit, v;
      r = '0;
      if (rq.cmd == CMD_GET) begin
         bk = rq.block_number % NBKT;
         hit = -1;
         for (int i = 0; i < NBUF; i++)
            if (tbl_bkt[i] == bk && tbl_dev[i] == rq.device_id &&
                tbl_blk[i] == rq.block_number &&
                (hit < 0 || tbl_order[i] > tbl_order[hit])) hit = i;
         if (hit >= 0) begin
            r.slot_out = hit[4:0];
            r.was_hit = 1'b1;
            if (tbl_refs[hit] == REFS_MAX) r.status = ST_OVERFLOW;
            else begin
               tbl_refs[hit]++;
               r.need_read = ~tbl_valid[hit];
               tbl_valid[hit] = 1'b1;
            end
            r.ref_count = tbl_refs[hit];
         end else begin
            v = oldest_free_in(bk);
            for (int b = 0; v < 0 && b < NBKT; b++) begin
               if (b == bk) continue;
               v = oldest_free_in(b);
               if (v >= 0) begin
                  tbl_bkt[v] = bk[5:0];
                  tbl_order[v] = next_order;
                  next_order++;
               end
            end
            if (v < 0) r.status = ST_NO_FREE;
            else begin
               tbl_dev[v] = rq.device_id;
               tbl_blk[v] = rq.block_number;
               tbl_refs[v] = 16'd1;
               tbl_stamp[v] = rq.now_ticks;
               tbl_valid[v] = 1'b1;
               r.slot_out = v[4:0];
               r.need_read = 1'b1;
               r.ref_count = 16'd1;
            end
         end
      end else begin
         r.slot_out = rq.buffer_slot;
         if (rq.buffer_slot < NBUF) begin
            if (rq.cmd == CMD_PIN) begin
               if (tbl_refs[rq.buffer_slot] == REFS_MAX) r.status = ST_OVERFLOW;
               else tbl_refs[rq.buffer_slot]++;
            end else if (tbl_refs[rq.buffer_slot] == 0) r.status = ST_UNDERFLOW;
            else begin
               tbl_refs[rq.buffer_slot]--;
               if (tbl_refs[rq.buffer_slot] == 0) tbl_stamp[rq.buffer_slot] = rq.now_ticks;
            end
            r.ref_count = tbl_refs[rq.buffer_slot];
         end
      end
      return r;
   endfunction

   function automatic req_type make_req(input logic [1:0] c, input logic [15:0] d,
                                        input logic [31:0] b, input logic [4:0] s,
                                        input logic [31:0] t);
      req_type rq;
      rq.cmd = c; rq.device_id = d; rq.block_number = b; rq.buffer_slot = s;
      rq.now_ticks = t;
      return rq;
   endfunction

   // Driver: present the next pending request, hold it while stalled.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         // the head request transferred at this edge; predict it
         if (req_valid) begin
            void'(pending_reqs.pop_front());
            expected_rsps.push_back(cache_access(req_data));
         end
         if (pending_reqs.size() > (req_valid ? 0 : 0) && !hold_off &&
             $urandom_range(99) >= send_idle_pct && pending_reqs.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Monitor: compare every response transfer with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_rsp++;
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("response with nothing expected: slot %0d", rsp_data.slot_out);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.slot_out != want.slot_out)
               report_mismatch("slot_out", rsp_data.slot_out, want.slot_out);
            if (rsp_data.was_hit != want.was_hit)
               report_mismatch("was_hit", rsp_data.was_hit, want.was_hit);
            if (rsp_data.need_read != want.need_read)
               report_mismatch("need_read", rsp_data.need_read, want.need_read);
            if (rsp_data.ref_count != want.ref_count)
               report_mismatch("ref_count", rsp_data.ref_count, want.ref_count);
            if (rsp_data.status != want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (want.was_hit) n_hits++;
            if (want.status == ST_NO_FREE) n_nofree++;
            if (want.status == ST_UNDERFLOW) n_under++;
            if (want.status == ST_OVERFLOW) n_over++;
         end
      end
   end

   // Timeout
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
   endtask

   // Random request: mostly gets, of small, recently used or random blocks, and count traffic.
   function automatic req_type rand_req();
      logic [1:0]  c;
      logic [15:0] d;
      logic [31:0] b;
      int k;
      c = $urandom_range(99) < 50 ? CMD_GET : 2'($urandom_range(3));
      d = 16'($urandom_range(3));
      b = 32'($urandom_range(40));
      if ($urandom_range(9) == 0) begin
         d = 16'($urandom);
         b = $urandom;
      end else if (seen_blk.size() != 0 && $urandom_range(1)) begin
         k = $urandom_range(seen_blk.size() - 1);
         d = seen_dev[k];
         b = seen_blk[k];
      end
      if (c == CMD_GET) begin
         seen_dev.push_back(d);
         seen_blk.push_back(b);
         if (seen_blk.size() > 24) begin
            void'(seen_dev.pop_front());
            void'(seen_blk.pop_front());
         end
      end
      return make_req(c, d, b, 5'($urandom), $urandom);
   endfunction

   initial begin
      for (int i = 0; i < NBUF; i++) begin
         tbl_dev[i] = '0; tbl_blk[i] = '0; tbl_refs[i] = '0; tbl_stamp[i] = '0;
         tbl_valid[i] = 1'b0; tbl_bkt[i] = 6'(i % NBKT); tbl_order[i] = 16'(i);
      end
      next_order = 16'(NBUF);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every command, underflow, hit, stamp of all ones
      pending_reqs.push_back(make_req(CMD_RELEASE, 16'h0, 32'h0, 5'd0, 32'h0));
      pending_reqs.push_back(make_req(CMD_UNPIN, 16'h0, 32'h0, 5'd31, 32'h0));
      pending_reqs.push_back(make_req(CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd0, 32'h5));
      pending_reqs.push_back(make_req(CMD_GET, 16'h0, 32'h0, 5'd0, 32'h0));
      pending_reqs.push_back(make_req(CMD_PIN, 16'h0, 32'h0, 5'd0, 32'h1));
      pending_reqs.push_back(make_req(CMD_UNPIN, 16'h0, 32'h0, 5'd0, 32'h1));
      pending_reqs.push_back(make_req(CMD_RELEASE, 16'h0, 32'h0, 5'd0, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(CMD_GET, 16'h0, 32'h0, 5'd0, 32'h7));
      pending_reqs.push_back(make_req(CMD_GET, 16'h1, 32'd13, 5'd0, 32'h7));
      pending_reqs.push_back(make_req(CMD_GET, 16'h1, 32'd26, 5'd0, 32'h8));
      pending_reqs.push_back(make_req(CMD_GET, 16'h1, 32'd39, 5'd0, 32'h9));
      pending_reqs.push_back(make_req(CMD_GET, 16'h1, 32'd52, 5'd0, 32'h9));
      wait_drained();

      // Pin every slot so a get runs out of buffers, then unpin every slot
      hold_off = 1'b0;
      for (int i = 0; i < NBUF; i++)
         pending_reqs.push_back(make_req(CMD_PIN, 16'h0, 32'h0, 5'(i), 32'h0));
      pending_reqs.push_back(make_req(CMD_GET, 16'h2, 32'd100, 5'd0, 32'h3));
      for (int i = 0; i < NBUF; i++)
         pending_reqs.push_back(make_req(CMD_UNPIN, 16'h0, 32'h0, 5'(i), 32'($urandom)));
      // Wait until everything is back, then pause the sender
      wait_drained();
      hold_off = 1'b1;
      repeat (20) @(posedge clock);
      hold_off = 1'b0;

      // Random phases with changing idle patterns
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 46 : 0;
         recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 23 : 0;
         for (int n = 0; n < 630; n++) begin
            pending_reqs.push_back(rand_req());
            if (n % 50 == 0) wait_drained();
         end
         wait_drained();
      end

      // Pin slot 3 three more times
      for (int i = 0; i < 3; i++)
         pending_reqs.push_back(make_req(CMD_PIN, 16'h0, 32'h0, 5'd3, 32'h0));
      wait_drained();
      repeat (60) @(posedge clock);

      $display("responses %0d: hits %0d, no free %0d, underflow %0d, overflow %0d",
               n_rsp, n_hits, n_nofree, n_under, n_over);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
